// ----- hw/rtl/frg_pkg.sv -----
// Shared types for the fraction reduction block.
// Holds the sequencer state enum; no dependencies.
package frg_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD_CHECK,
        ST_GCD_WAIT,
        ST_DIVN_WAIT,
        ST_DIVD_WAIT,
        ST_FINISH
    } t_frg_state;

endpackage

// ----- hw/rtl/frg_divider.sv -----
// Iterative restoring unsigned divider, one quotient bit per cycle.
// Shared by the gcd loop and the two final divisions; no package use.
module frg_divider #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quotient,
    output logic [DATA_WIDTH-1:0] o_remainder
);
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_div;
    logic [DATA_WIDTH:0]   trial;

    // partial remainder stays below the divisor (at most 2^(W-1)), so top bit is free
    assign trial = {r_rem, r_quo[DATA_WIDTH-1]} - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DATA_WIDTH);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (!trial[DATA_WIDTH]) begin
                    r_rem <= trial[DATA_WIDTH-1:0];
                    r_quo <= {r_quo[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[DATA_WIDTH-2:0], r_quo[DATA_WIDTH-1]};
                    r_quo <= {r_quo[DATA_WIDTH-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- hw/rtl/fraction_reduce_gcd_top.sv -----
// Fraction reduction: Euclid gcd on magnitudes, then both divided by it.
// Every Euclid step and both final divisions run on one bit-serial divider.
// Input stalls while a fraction is in work.
// Both inputs zero: 0/0 with zero_error, skipping gcd and divisions. Synchronous active-low reset.
// Depends on frg_pkg and frg_divider.
module fraction_reduce_gcd_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [DATA_WIDTH-1:0] i_numerator_in,
    input  logic signed [DATA_WIDTH-1:0] i_denominator_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_numerator_out,
    output logic        [DATA_WIDTH-2:0] o_denominator_out,
    output logic                         o_zero_error
);
    import frg_pkg::*;

    t_frg_state r_state, n_state;

    logic [DATA_WIDTH-1:0] r_nm, r_dm, r_a, r_b, r_qn, r_qd;
    logic                  r_nneg, r_dneg, r_err;
    logic                  r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_num_out;
    logic        [DATA_WIDTH-2:0] r_den_out;
    logic                  r_err_out;

    logic [DATA_WIDTH-1:0] in_nm, in_dm;
    logic                  in_zero;
    logic                  div_start, div_done;
    logic [DATA_WIDTH-1:0] div_dividend, div_divisor, div_quo, div_rem;
    logic                  accept_in, load_out;
    logic [DATA_WIDTH-1:0] qn_sat, num_val;
    logic [DATA_WIDTH-2:0] den_val;
    logic                  neg;

    assign in_nm   = i_numerator_in[DATA_WIDTH-1] ? -i_numerator_in : i_numerator_in;
    assign in_dm   = i_denominator_in[DATA_WIDTH-1] ? -i_denominator_in : i_denominator_in;
    assign in_zero = (in_nm == '0) && (in_dm == '0);

    frg_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = in_zero ? ST_FINISH : ST_GCD_CHECK;
            ST_GCD_CHECK: n_state = (r_b == '0) ? ST_DIVN_WAIT : ST_GCD_WAIT;
            ST_GCD_WAIT:  if (div_done) n_state = ST_GCD_CHECK;
            ST_DIVN_WAIT: if (div_done) n_state = ST_DIVD_WAIT;
            ST_DIVD_WAIT: if (div_done) n_state = ST_FINISH;
            ST_FINISH:    if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        accept_in    = 1'b0;
        load_out     = 1'b0;
        div_start    = 1'b0;
        div_dividend = r_a;
        div_divisor  = r_b;
        unique case (r_state)
            ST_IDLE:      accept_in = i_in_valid;
            ST_GCD_CHECK: begin
                div_start = 1'b1;
                if (r_b == '0) begin
                    // gcd found in r_a: divide numerator magnitude by it
                    div_dividend = r_nm;
                    div_divisor  = r_a;
                end
            end
            ST_DIVN_WAIT: begin
                div_start    = div_done;
                div_dividend = r_dm;
                div_divisor  = r_a;
            end
            ST_FINISH:    load_out = !r_out_valid || !i_out_stall;
            default:      ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_nm   <= in_nm;
            r_dm   <= in_dm;
            r_a    <= in_nm;
            r_b    <= in_dm;
            r_nneg <= i_numerator_in[DATA_WIDTH-1];
            r_dneg <= i_denominator_in[DATA_WIDTH-1];
            r_err  <= in_zero;
            r_qn   <= '0;
            r_qd   <= '0;
        end
        if (r_state == ST_GCD_WAIT && div_done) begin
            r_a <= r_b;
            r_b <= div_rem;
        end
        if (r_state == ST_DIVN_WAIT && div_done) begin
            r_qn <= div_quo;
        end
        if (r_state == ST_DIVD_WAIT && div_done) begin
            r_qd <= div_quo;
        end
    end

    // saturate magnitudes to 2^(W-1)-1 and move the sign onto the numerator
    assign qn_sat  = r_qn[DATA_WIDTH-1] ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : r_qn;
    assign den_val = r_qd[DATA_WIDTH-1] ? {(DATA_WIDTH-1){1'b1}} : r_qd[DATA_WIDTH-2:0];
    assign neg     = (r_qn != '0) && ((r_dm == '0) ? r_nneg : (r_nneg ^ r_dneg));
    assign num_val = neg ? -qn_sat : qn_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_num_out <= r_err ? '0 : num_val;
            r_den_out <= r_err ? '0 : den_val;
            r_err_out <= r_err;
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_numerator_out   = r_num_out;
    assign o_denominator_out = r_den_out;
    assign o_zero_error      = r_err_out;

endmodule
